[sv/bec_pkg.sv]
// ----------------------------------------------------------------------------
// bec_pkg
// Shared constants and types for the blocked-ELL column index builder.
// ----------------------------------------------------------------------------
package bec_pkg;

   localparam int MAX_BLOCK_COLS = 64;
   localparam int COL_BITS       = 12;

   localparam int BLK_IDX_W = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
   localparam int COUNT_W   = $clog2(MAX_BLOCK_COLS + 1);

   localparam int SHIFT_W    = 3;
   localparam int SLOT_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int MAX_SHIFT  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COLS  = 2'd1;

   localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RESET = 3'd1;
   localparam logic [SLOT_W-1:0]  BLOCK_COLS_RESET  = 7'd64;

   localparam logic signed [SLOT_W-1:0] PAD_BLOCK = -7'sd1;

   typedef struct packed {
      logic mark;   // mark the column block of the accepted request
      logic start;  // row end accepted: capture overflow, reset slot counter
      logic step;   // load the next slot into the response register
   } bec_cmd_type;

   typedef struct packed {
      logic last;   // current slot is the final one of the block row
   } bec_sts_type;

endpackage

[sv/blocked_ell_column_index_builder.sv]
// ----------------------------------------------------------------------------
// blocked_ell_column_index_builder
// Builds blocked-ELL column block indices from CSR-ordered column indices.
// ----------------------------------------------------------------------------
//
//   port group | direction | handshake          | payload
//   -----------+-----------+--------------------+----------------------------------
//   req_*      | in        | req_valid/stall    | col_index, has_entry, end_of_block_row
//   rsp_*      | out       | rsp_valid/stall    | block_col, last_slot, overflow
//   csr_*      | in        | csr_valid/ready    | index (0 shift, 1 cols), wdata
//
// A request with an entry (row end or not) has its column block marked in
// a 64-bit bitmap and a distinct block count is kept alongside.
// A row end request stalls the request side until all of its slots (1 to 64
// slots) are loaded; filled slots come from a lowest-set-bit search over the bitmap.
// The response register decouples the sides; a stalled response holds the walk.
// Reset clears the bitmap, count and range flag at once; block_shift resets to 1
// and block_cols to 64. The configuration port is always ready.
// ----------------------------------------------------------------------------
module blocked_ell_column_index_builder (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bec_pkg::COL_BITS-1:0]         req_col_index,
   input  logic                                 req_has_entry,
   input  logic                                 req_end_of_block_row,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bec_pkg::SLOT_W-1:0]    rsp_block_col,
   output logic                                 rsp_last_slot,
   output logic                                 rsp_overflow,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bec_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bec_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import bec_pkg::*;

   bec_cmd_type cmd;
   bec_sts_type sts;

   // Configuration writes are never back-pressured.
   assign csr_ready = 1'b1;

   // Sequence handshakes and the per-row slot walk.
   bec_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_has_entry        (req_has_entry),
      .req_end_of_block_row (req_end_of_block_row),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .sts                  (sts),
      .cmd                  (cmd)
   );

   // Hold the bitmap, configuration and response payload.
   bec_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_col_index (req_col_index),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_block_col (rsp_block_col),
      .rsp_last_slot (rsp_last_slot),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

[sv/bec_datapath.sv]
// ----------------------------------------------------------------------------
// bec_datapath
// Column-block bitmap, distinct block count, slot walker and response register.
// ----------------------------------------------------------------------------
module bec_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [bec_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bec_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [bec_pkg::COL_BITS-1:0]         req_col_index,
   input  bec_pkg::bec_cmd_type                 cmd,
   output bec_pkg::bec_sts_type                 sts,
   output logic signed [bec_pkg::SLOT_W-1:0]    rsp_block_col,
   output logic                                 rsp_last_slot,
   output logic                                 rsp_overflow
);
   import bec_pkg::*;

   logic [SHIFT_W-1:0]        block_shift_ff, block_shift_in;
   logic [SLOT_W-1:0]         block_cols_ff, block_cols_in;
   logic [MAX_BLOCK_COLS-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      range_ff, range_in;
   logic                      extra_ff, extra_in;
   logic [SLOT_W-1:0]         idx_ff, idx_in;
   logic signed [SLOT_W-1:0]  block_col_ff, block_col_in;
   logic                      last_ff, last_in;
   logic                      ovf_ff, ovf_in;

   logic [SHIFT_W-1:0]        shift;
   logic [COL_BITS-1:0]       blk;
   logic                      blk_in_range;
   logic [BLK_IDX_W-1:0]      blk_bit;
   logic [MAX_BLOCK_COLS-1:0] seen_mark;
   logic [COUNT_W-1:0]        count_mark;
   logic                      range_mark;
   logic [SLOT_W-1:0]         slots;
   logic [MAX_BLOCK_COLS-1:0] lowest;
   logic [SLOT_W-1:0]         lowest_idx;
   logic                      is_last;

   // Saturate the configuration as the row walker sees it.
   always_comb begin
      shift = (block_shift_ff > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : block_shift_ff;
      if (block_cols_ff == '0) begin
         slots = SLOT_W'(1);
      end else if (32'(block_cols_ff) > MAX_BLOCK_COLS) begin
         slots = SLOT_W'(MAX_BLOCK_COLS);
      end else begin
         slots = block_cols_ff;
      end
   end

   // Mark the incoming column block; count only newly set bits.
   always_comb begin
      blk          = req_col_index >> shift;
      blk_in_range = (32'(blk) < MAX_BLOCK_COLS);
      blk_bit      = blk[BLK_IDX_W-1:0];
      seen_mark    = seen_ff;
      count_mark   = count_ff;
      range_mark   = range_ff;
      if (cmd.mark) begin
         if (blk_in_range) begin
            seen_mark[blk_bit] = 1'b1;
            if (!seen_ff[blk_bit]) begin
               count_mark = count_ff + COUNT_W'(1);
            end
         end else begin
            range_mark = 1'b1;
         end
      end
   end

   // Isolate the lowest pending block and encode its index.
   always_comb begin
      lowest     = seen_ff & (~seen_ff + MAX_BLOCK_COLS'(1));
      lowest_idx = '0;
      for (int i = 0; i < MAX_BLOCK_COLS; i++) begin
         if (lowest[i]) begin
            lowest_idx = lowest_idx | SLOT_W'(i);
         end
      end
   end

   assign is_last  = ({1'b0, idx_ff} + 8'd1) == {1'b0, slots};
   assign sts.last = is_last;

   always_comb begin
      block_shift_in = block_shift_ff;
      block_cols_in  = block_cols_ff;
      seen_in        = seen_mark;
      count_in       = count_mark;
      range_in       = range_mark;
      extra_in       = extra_ff;
      idx_in         = idx_ff;
      block_col_in   = block_col_ff;
      last_in        = last_ff;
      ovf_in         = ovf_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_BLOCK_SHIFT: block_shift_in = csr_wdata[SHIFT_W-1:0];
            CSR_BLOCK_COLS:  block_cols_in  = csr_wdata[SLOT_W-1:0];
            default:         ;
         endcase
      end

      if (cmd.start) begin
         extra_in = range_mark || (32'(count_mark) > 32'(slots));
         idx_in   = '0;
      end

      if (cmd.step) begin
         block_col_in = (seen_ff != '0) ? lowest_idx : PAD_BLOCK;
         last_in      = is_last;
         ovf_in       = extra_ff;
         idx_in       = idx_ff + SLOT_W'(1);
         seen_in      = seen_ff & ~lowest;
         if (is_last) begin
            seen_in  = '0;
            count_in = '0;
            range_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff <= BLOCK_SHIFT_RESET;
         block_cols_ff  <= BLOCK_COLS_RESET;
         seen_ff        <= '0;
         count_ff       <= '0;
         range_ff       <= 1'b0;
         extra_ff       <= 1'b0;
         idx_ff         <= '0;
      end else begin
         block_shift_ff <= block_shift_in;
         block_cols_ff  <= block_cols_in;
         seen_ff        <= seen_in;
         count_ff       <= count_in;
         range_ff       <= range_in;
         extra_ff       <= extra_in;
         idx_ff         <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      block_col_ff <= block_col_in;
      last_ff      <= last_in;
      ovf_ff       <= ovf_in;
   end

   assign rsp_block_col = block_col_ff;
   assign rsp_last_slot = last_ff;
   assign rsp_overflow  = ovf_ff;

   a_clear_after_row: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.last) |=> (seen_ff == '0 && count_ff == '0 && !range_ff))
      else $error("bitmap not cleared after the final slot");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (idx_ff < slots))
      else $error("slot walker ran past the slot count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_BLOCK_COLS)
      else $error("distinct block count above bitmap size");

endmodule

[sv/bec_ctrl.sv]
// ----------------------------------------------------------------------------
// bec_ctrl
// Request/response handshake control and row emission state machine.
// ----------------------------------------------------------------------------
module bec_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_has_entry,
   input  logic                  req_end_of_block_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bec_pkg::bec_sts_type  sts,
   output bec_pkg::bec_cmd_type  cmd
);
   import bec_pkg::*;

   typedef enum logic {
      IDLE,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      out_free;

   assign req_stall  = (state_ff == EMIT);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.mark  = req_accept && req_has_entry;
      cmd.start = req_accept && req_end_of_block_row;
      cmd.step  = (state_ff == EMIT) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         IDLE: begin
            if (cmd.start) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (cmd.step) begin
               rsp_valid_in = 1'b1;
               if (sts.last) begin
                  state_in = IDLE;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.last) |=> (state_ff == IDLE))
      else $error("emission did not end after the final slot");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rsp_valid_ff)
      else $error("loaded slot not presented");

   a_start_to_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == EMIT && !rsp_valid_in || state_ff == EMIT))
      else $error("row end did not start emission");

endmodule
